// ----- rtl/sfdf_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, item types and helper functions of the signed fixed decimal formatter.
package sfdf_pkg;

	// Q16.16 input word, with one extra bit so that -2^32 has a magnitude
	localparam int VALUE_W = 33;
	localparam int FRAC_W  = 16;
	localparam int IPART_W = VALUE_W - FRAC_W;
	// scaled fraction stays below 10^4
	localparam int DEC_W   = 14;

	// integer part never exceeds 2^16, so five digits hold every non-zero digit
	localparam int INT_DIG_N   = 5;
	localparam int FRAC_DIG_N  = 4;
	localparam int DIV_STAGES  = (INT_DIG_N > FRAC_DIG_N) ? INT_DIG_N : FRAC_DIG_N;
	localparam int IDIG_IDX_W  = $clog2(INT_DIG_N);
	localparam int FDIG_IDX_W  = $clog2(FRAC_DIG_N);

	// digit counts and character position within one string
	localparam int CNT_W = 3;
	localparam int POS_W = 4;

	// queue between the front and the back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;

	localparam logic [CNT_W-1:0] INT_DIGITS_RST  = 3'd5;
	localparam logic [CNT_W-1:0] FRAC_DIGITS_RST = 3'd2;

	// x / 10 == (x * 52429) >> 19, exact for every x below 2^17
	localparam logic [IPART_W-1:0] RECIP10    = 17'd52429;
	localparam int                 RECIP10_SH = 19;

	typedef enum logic [0:0] {
		REG_INT_DIGITS  = 1'b0,
		REG_FRAC_DIGITS = 1'b1
	} reg_idx_t;

	// one value, classified and split into decimal digits (index 0 least significant)
	typedef struct packed {
		logic                         neg;
		logic [CNT_W-1:0]             nint;
		logic [CNT_W-1:0]             nfrac;
		logic [INT_DIG_N-1:0][3:0]    idig;
		logic [FRAC_DIG_N-1:0][3:0]   fdig;
	} entry_t;

	// queue status seen by its neighbours
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [IPART_W-1:0] q;
		logic [3:0]         r;
	} divmod_t;

	// quotient and remainder by ten through the reciprocal
	function automatic divmod_t div10(input logic [IPART_W-1:0] x);
		logic [2*IPART_W-1:0] prod;
		logic [IPART_W-1:0]   quo;
		logic [IPART_W-1:0]   tenq;
		divmod_t              res;
		prod     = (2*IPART_W)'(x) * (2*IPART_W)'(RECIP10);
		quo      = IPART_W'(prod >> RECIP10_SH);
		tenq     = IPART_W'((quo << 3) + (quo << 1));
		res.q    = quo;
		res.r    = 4'(x - tenq);
		return res;
	endfunction

	// 10^n for the fraction scaling
	function automatic logic [DEC_W-1:0] pow10(input logic [CNT_W-1:0] n);
		logic [DEC_W-1:0] res;
		case (n)
			3'd1:    res = 14'd10;
			3'd2:    res = 14'd100;
			3'd3:    res = 14'd1000;
			3'd4:    res = 14'd10000;
			default: res = 14'd1;
		endcase
		return res;
	endfunction

endpackage

// ----- rtl/sfdf_front.sv -----
`timescale 1ns / 1ps
// Front end: configuration registers, sign and magnitude split, digit extraction pipeline.
module sfdf_front #(
	parameter int INT_DIGITS_MAX  = 5,
	parameter int FRAC_DIGITS_MAX = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [0:0]                          wr_index,
	input  logic [sfdf_pkg::CNT_W-1:0]          wr_data,
	input  logic                                push,
	input  logic signed [sfdf_pkg::VALUE_W-1:0] value,
	output logic                                full,
	output logic                                out_valid,
	output sfdf_pkg::entry_t                    out_entry,
	input  logic                                queue_full
);

	typedef struct packed {
		sfdf_pkg::entry_t                 e;
		logic [sfdf_pkg::IPART_W-1:0]     ip;
		logic [sfdf_pkg::DEC_W-1:0]       fr;
	} dstage_t;

	logic [sfdf_pkg::CNT_W-1:0] int_digits_q;
	logic [sfdf_pkg::CNT_W-1:0] frac_digits_q;

	logic                                              adv;
	logic [sfdf_pkg::VALUE_W-1:0]                      vu_c;
	logic [sfdf_pkg::VALUE_W-1:0]                      mag_c;
	logic [sfdf_pkg::CNT_W-1:0]                        nint_c;
	logic [sfdf_pkg::CNT_W-1:0]                        nfrac_c;
	logic [sfdf_pkg::FRAC_W+sfdf_pkg::DEC_W-1:0]       fprod_c;

	logic                           v_s1;
	logic                           neg_s1;
	logic [sfdf_pkg::IPART_W-1:0]   ipart_s1;
	logic [sfdf_pkg::FRAC_W-1:0]    fpart_s1;
	logic [sfdf_pkg::CNT_W-1:0]     nint_s1;
	logic [sfdf_pkg::CNT_W-1:0]     nfrac_s1;

	logic                           v_s2;
	logic                           neg_s2;
	logic [sfdf_pkg::IPART_W-1:0]   ipart_s2;
	logic [sfdf_pkg::DEC_W-1:0]     dec_s2;
	logic [sfdf_pkg::CNT_W-1:0]     nint_s2;
	logic [sfdf_pkg::CNT_W-1:0]     nfrac_s2;

	// divider stages s3 onwards, one decimal digit of each part per stage
	dstage_t                         dv_s   [sfdf_pkg::DIV_STAGES];
	logic [sfdf_pkg::DIV_STAGES-1:0] dv_v_s;
	dstage_t                         src_c  [sfdf_pkg::DIV_STAGES];
	dstage_t                         nxt_c  [sfdf_pkg::DIV_STAGES];
	sfdf_pkg::divmod_t               idm_c  [sfdf_pkg::DIV_STAGES];
	sfdf_pkg::divmod_t               fdm_c  [sfdf_pkg::DIV_STAGES];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_digits_q  <= sfdf_pkg::INT_DIGITS_RST;
			frac_digits_q <= sfdf_pkg::FRAC_DIGITS_RST;
		end else if (wr_en) begin
			unique case (sfdf_pkg::reg_idx_t'(wr_index))
				sfdf_pkg::REG_INT_DIGITS:  int_digits_q  <= wr_data;
				sfdf_pkg::REG_FRAC_DIGITS: frac_digits_q <= wr_data;
			endcase
		end
	end

	// whole pipeline moves together; it halts only when its last item cannot enter the queue
	assign adv       = !out_valid || !queue_full;
	assign full      = !adv;
	assign out_valid = dv_v_s[sfdf_pkg::DIV_STAGES-1];
	assign out_entry = dv_s[sfdf_pkg::DIV_STAGES-1].e;

	// sign, magnitude and saturated digit counts
	always_comb begin
		vu_c    = value;
		mag_c   = vu_c[sfdf_pkg::VALUE_W-1] ? (~vu_c + sfdf_pkg::VALUE_W'(1)) : vu_c;
		nint_c  = (int'(int_digits_q) > INT_DIGITS_MAX) ?
			sfdf_pkg::CNT_W'(INT_DIGITS_MAX) : int_digits_q;
		nfrac_c = (int'(frac_digits_q) > FRAC_DIGITS_MAX) ?
			sfdf_pkg::CNT_W'(FRAC_DIGITS_MAX) : frac_digits_q;
	end

	// fraction scaled by 10^nfrac, truncated
	assign fprod_c = (sfdf_pkg::FRAC_W + sfdf_pkg::DEC_W)'(fpart_s1) *
		(sfdf_pkg::FRAC_W + sfdf_pkg::DEC_W)'(sfdf_pkg::pow10(nfrac_s1));

	// divide-by-ten stages
	always_comb begin
		src_c[0]         = '0;
		src_c[0].e.neg   = neg_s2;
		src_c[0].e.nint  = nint_s2;
		src_c[0].e.nfrac = nfrac_s2;
		src_c[0].ip      = ipart_s2;
		src_c[0].fr      = dec_s2;
		for (int k = 1; k < sfdf_pkg::DIV_STAGES; k++) begin
			src_c[k] = dv_s[k-1];
		end
		for (int k = 0; k < sfdf_pkg::DIV_STAGES; k++) begin
			idm_c[k]    = sfdf_pkg::div10(src_c[k].ip);
			fdm_c[k]    = sfdf_pkg::div10(sfdf_pkg::IPART_W'(src_c[k].fr));
			nxt_c[k]    = src_c[k];
			nxt_c[k].ip = idm_c[k].q;
			nxt_c[k].fr = sfdf_pkg::DEC_W'(fdm_c[k].q);
			if (k < sfdf_pkg::INT_DIG_N) begin
				nxt_c[k].e.idig[sfdf_pkg::IDIG_IDX_W'(k)] = idm_c[k].r;
			end
			if (k < sfdf_pkg::FRAC_DIG_N) begin
				nxt_c[k].e.fdig[sfdf_pkg::FDIG_IDX_W'(k)] = fdm_c[k].r;
			end
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			dv_v_s <= '0;
		end else if (adv) begin
			v_s1   <= push;
			v_s2   <= v_s1;
			dv_v_s <= {dv_v_s[sfdf_pkg::DIV_STAGES-2:0], v_s2};
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1   <= vu_c[sfdf_pkg::VALUE_W-1];
			ipart_s1 <= mag_c[sfdf_pkg::VALUE_W-1:sfdf_pkg::FRAC_W];
			fpart_s1 <= mag_c[sfdf_pkg::FRAC_W-1:0];
			nint_s1  <= nint_c;
			nfrac_s1 <= nfrac_c;

			neg_s2   <= neg_s1;
			ipart_s2 <= ipart_s1;
			dec_s2   <= fprod_c[sfdf_pkg::FRAC_W +: sfdf_pkg::DEC_W];
			nint_s2  <= nint_s1;
			nfrac_s2 <= nfrac_s1;

			for (int k = 0; k < sfdf_pkg::DIV_STAGES; k++) begin
				dv_s[k] <= nxt_c[k];
			end
		end
	end

endmodule

// ----- rtl/sfdf_queue.sv -----
`timescale 1ns / 1ps
// Short item queue between the digit extraction front and the character back end.
module sfdf_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  sfdf_pkg::entry_t  in_entry,
	input  logic              pop,
	output sfdf_pkg::entry_t  head,
	output sfdf_pkg::q_stat_t stat
);

	sfdf_pkg::entry_t             mem_q [sfdf_pkg::QUEUE_DEPTH];
	logic [sfdf_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [sfdf_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [sfdf_pkg::QCNT_W-1:0]  count_q;
	logic                         wr;
	logic                         rd;

	assign stat.full  = (count_q == sfdf_pkg::QCNT_W'(sfdf_pkg::QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign wr         = in_valid && !stat.full;
	assign rd         = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= in_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == sfdf_pkg::QPTR_W'(sfdf_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + sfdf_pkg::QPTR_W'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == sfdf_pkg::QPTR_W'(sfdf_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + sfdf_pkg::QPTR_W'(1);
			end
			count_q <= count_q + sfdf_pkg::QCNT_W'(wr) - sfdf_pkg::QCNT_W'(rd);
		end
	end

endmodule

// ----- rtl/sfdf_back.sv -----
`timescale 1ns / 1ps
// Back end: walks the queue head character by character into the output register.
module sfdf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  sfdf_pkg::entry_t head,
	input  logic             q_empty,
	output logic             q_pop,
	output logic [7:0]       char_out,
	output logic             last,
	output logic             empty,
	input  logic             pop
);

	logic [sfdf_pkg::POS_W-1:0] pos_q;
	logic                       ovalid_q;
	logic [7:0]                 char_q;
	logic                       last_q;

	logic [sfdf_pkg::POS_W-1:0] q_c;
	logic [sfdf_pkg::POS_W-1:0] nint_c;
	logic [sfdf_pkg::POS_W-1:0] nfrac_c;
	logic [sfdf_pkg::POS_W-1:0] idx_c;
	logic [sfdf_pkg::POS_W-1:0] fidx_c;
	logic                       sign_c;
	logic [7:0]                 ch_c;
	logic                       last_c;
	logic                       emit;

	// character at the current position of the head item
	always_comb begin
		nint_c  = sfdf_pkg::POS_W'(head.nint);
		nfrac_c = sfdf_pkg::POS_W'(head.nfrac);
		sign_c  = head.neg && (pos_q == '0);
		// position counted from the first integer digit
		q_c     = pos_q - sfdf_pkg::POS_W'(head.neg);
		idx_c   = nint_c - q_c - sfdf_pkg::POS_W'(1);
		fidx_c  = nint_c + nfrac_c - q_c;
		last_c  = !sign_c && (q_c == nint_c + nfrac_c);
		if (sign_c) begin
			ch_c = sfdf_pkg::CH_MINUS;
		end else if (q_c < nint_c) begin
			// digits above the fifth are always zero
			if (idx_c < sfdf_pkg::POS_W'(sfdf_pkg::INT_DIG_N)) begin
				ch_c = sfdf_pkg::CH_ZERO +
					8'(head.idig[idx_c[sfdf_pkg::IDIG_IDX_W-1:0]]);
			end else begin
				ch_c = sfdf_pkg::CH_ZERO;
			end
		end else if (q_c == nint_c) begin
			ch_c = sfdf_pkg::CH_POINT;
		end else begin
			ch_c = sfdf_pkg::CH_ZERO + 8'(head.fdig[fidx_c[sfdf_pkg::FDIG_IDX_W-1:0]]);
		end
	end

	// a character moves out when the output register is free or being emptied
	assign emit     = !q_empty && (!ovalid_q || pop);
	assign q_pop    = emit && last_c;
	assign empty    = !ovalid_q;
	assign char_out = char_q;
	assign last     = last_q;

	// position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (emit) begin
				pos_q    <= last_c ? '0 : pos_q + sfdf_pkg::POS_W'(1);
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= ch_c;
			last_q <= last_c;
		end
	end

endmodule

// ----- rtl/signed_fixed_decimal_formatter_unit.sv -----
`timescale 1ns / 1ps
// Top level of the signed fixed decimal formatter: front, queue and character back end.
// The first character of a value reaches the result ports after the front stages and the queue.
// Input: one value per cycle while the front (two stages plus five divide-by-ten stages)
// can hand its oldest item to the two-entry queue.
// Output: one character per cycle while pop is high, sign + int_digits + 1 + frac_digits per value, 11 at most.
// Reset (arst_n low, asynchronous): all stages emptied, int_digits = 5, frac_digits = 2.
module signed_fixed_decimal_formatter_unit #(
	parameter int INT_DIGITS_MAX  = 5,
	parameter int FRAC_DIGITS_MAX = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [0:0]                          wr_index,
	input  logic [sfdf_pkg::CNT_W-1:0]          wr_data,
	input  logic                                push,
	output logic                                full,
	input  logic signed [sfdf_pkg::VALUE_W-1:0] value,
	output logic                                empty,
	input  logic                                pop,
	output logic [7:0]                          char_out,
	output logic                                last
);

	logic              front_valid;
	sfdf_pkg::entry_t  front_entry;
	sfdf_pkg::entry_t  q_head;
	sfdf_pkg::q_stat_t q_stat;
	logic              q_pop;

	// digit extraction
	sfdf_front #(
		.INT_DIGITS_MAX  (INT_DIGITS_MAX),
		.FRAC_DIGITS_MAX (FRAC_DIGITS_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.push       (push),
		.value      (value),
		.full       (full),
		.out_valid  (front_valid),
		.out_entry  (front_entry),
		.queue_full (q_stat.full)
	);

	// decoupling queue
	sfdf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (front_valid),
		.in_entry (front_entry),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	// character sequencing
	sfdf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.q_empty  (q_stat.empty),
		.q_pop    (q_pop),
		.char_out (char_out),
		.last     (last),
		.empty    (empty),
		.pop      (pop)
	);

	// front stalls only behind a full queue
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (front_valid && q_stat.full))
		else $error("front stalled without a full queue");

	// the back end retires only items that are present
	a_pop_present: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	// a stalled front keeps its finished item
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(front_valid && q_stat.full) |=> front_valid)
		else $error("front dropped an item while stalled");

endmodule

// ----- test/sfdf_checker.sv -----
`timescale 1ns / 1ps
// Checker for the decimal formatter: predicts the characters of every item and compares them.
module sfdf_checker #(
	parameter int INT_DIGITS_MAX  = 5,
	parameter int FRAC_DIGITS_MAX = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [0:0]                          wr_index,
	input  logic [sfdf_pkg::CNT_W-1:0]          wr_data,
	input  logic                                push,
	input  logic                                full,
	input  logic signed [sfdf_pkg::VALUE_W-1:0] value,
	input  logic                                empty,
	input  logic                                pop,
	input  logic [7:0]                          char_out,
	input  logic                                last,
	output int                                  errors,
	output int                                  chars_due
);

	localparam int unsigned RADIX = 10;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_item_t;

	// characters still owed by the block, oldest first
	char_item_t                 pending_chars[$];
	char_item_t                 want_char;
	logic [sfdf_pkg::CNT_W-1:0] int_cfg;
	logic [sfdf_pkg::CNT_W-1:0] frac_cfg;
	int                         char_no;

	initial errors = 0;

	task automatic report_mismatch(input string msg);
		$display("%0t: character %0d: %s", $time, char_no, msg);
		errors++;
	endtask

	// expected string of one item, queued in emission order
	task automatic format_value(input logic [sfdf_pkg::VALUE_W-1:0] raw);
		logic                         neg;
		logic [sfdf_pkg::VALUE_W-1:0] mag;
		int unsigned                  ipart;
		int unsigned                  nint;
		int unsigned                  nfrac;
		longint unsigned              scaled;
		int unsigned                  digs[INT_DIGITS_MAX + FRAC_DIGITS_MAX];
		int unsigned                  i;
		neg    = raw[sfdf_pkg::VALUE_W-1];
		mag    = neg ? (sfdf_pkg::VALUE_W'(0) - raw) : raw;
		ipart  = mag[sfdf_pkg::VALUE_W-1:sfdf_pkg::FRAC_W];
		scaled = mag[sfdf_pkg::FRAC_W-1:0];
		// digit counts saturate at the maxima
		nint   = (int_cfg > INT_DIGITS_MAX) ? INT_DIGITS_MAX : int_cfg;
		nfrac  = (frac_cfg > FRAC_DIGITS_MAX) ? FRAC_DIGITS_MAX : frac_cfg;
		for (i = 0; i < nfrac; i++)
			scaled = scaled * RADIX;
		scaled = scaled >> sfdf_pkg::FRAC_W;

		if (neg)
			pending_chars.push_back('{sfdf_pkg::CH_MINUS, 1'b0});

		// integer part modulo 10^nint, leading zeros kept
		for (i = 0; i < nint; i++) begin
			digs[nint-1-i] = ipart % RADIX;
			ipart = ipart / RADIX;
		end
		for (i = 0; i < nint; i++)
			pending_chars.push_back('{8'(sfdf_pkg::CH_ZERO + digs[i]), 1'b0});

		pending_chars.push_back('{sfdf_pkg::CH_POINT, (nfrac == 0)});

		// truncated fraction digits
		for (i = 0; i < nfrac; i++) begin
			digs[nfrac-1-i] = scaled % RADIX;
			scaled = scaled / RADIX;
		end
		for (i = 0; i < nfrac; i++)
			pending_chars.push_back('{8'(sfdf_pkg::CH_ZERO + digs[i]), (i + 1 == nfrac)});
	endtask

	// register copy, prediction on push, comparison on pop
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_cfg  <= sfdf_pkg::INT_DIGITS_RST;
			frac_cfg <= sfdf_pkg::FRAC_DIGITS_RST;
			pending_chars.delete();
			chars_due <= 0;
			char_no   <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					sfdf_pkg::REG_INT_DIGITS:  int_cfg  <= wr_data;
					sfdf_pkg::REG_FRAC_DIGITS: frac_cfg <= wr_data;
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (pending_chars.size() == 0) begin
					report_mismatch($sformatf("char_out %h with no item pending", char_out));
				end else begin
					want_char = pending_chars.pop_front();
					if (char_out !== want_char.ch)
						report_mismatch($sformatf("char_out %h, expected %h",
							char_out, want_char.ch));
					if (last !== want_char.last)
						report_mismatch($sformatf("last %b, expected %b",
							last, want_char.last));
				end
				char_no <= char_no + 1;
			end
			if (push && !full)
				format_value(value);
			chars_due <= pending_chars.size();
		end
	end

endmodule

// ----- test/tb_signed_fixed_decimal_formatter_unit.sv -----
`timescale 1ns / 1ps
// Testbench top for the decimal formatter: stimulus, register phases and the verdict.
module tb_signed_fixed_decimal_formatter_unit;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 46;

	logic                                clk      = 1'b0;
	logic                                arst_n   = 1'b0;
	logic                                wr_en    = 1'b0;
	logic [0:0]                          wr_index = '0;
	logic [sfdf_pkg::CNT_W-1:0]          wr_data  = '0;
	logic                                push     = 1'b0;
	logic signed [sfdf_pkg::VALUE_W-1:0] value    = '0;
	logic                                pop      = 1'b0;
	logic                                gaps_on  = 1'b1;
	logic                                full;
	logic                                empty;
	logic [7:0]                          char_out;
	logic                                last;
	int                                  errors;
	int                                  chars_due;
	int                                  idle_cycles = 0;

	signed_fixed_decimal_formatter_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.push     (push),
		.full     (full),
		.value    (value),
		.empty    (empty),
		.pop      (pop),
		.char_out (char_out),
		.last     (last)
	);

	sfdf_checker CHK (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.push      (push),
		.full      (full),
		.value     (value),
		.empty     (empty),
		.pop       (pop),
		.char_out  (char_out),
		.last      (last),
		.errors    (errors),
		.chars_due (chars_due)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// result side: pop with random stalls
	always @(posedge clk) begin
		pop <= arst_n && (!gaps_on || $urandom_range(0, 99) >= 6);
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || wr_en || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one item, with an occasional gap before it; returns at the accepting edge
	task automatic send_value(input logic signed [sfdf_pkg::VALUE_W-1:0] v);
		while (gaps_on && $urandom_range(0, 99) < 6) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push  <= 1'b1;
		value <= v;
		do @(posedge clk); while (full);
	endtask

	// hold off input until every character has come out, then let the pipeline settle
	task automatic drain_output();
		push <= 1'b0;
		@(posedge clk);
		while (chars_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input int unsigned nint, input int unsigned nfrac);
		wr_en    <= 1'b1;
		wr_index <= sfdf_pkg::REG_INT_DIGITS;
		wr_data  <= sfdf_pkg::CNT_W'(nint);
		@(posedge clk);
		wr_index <= sfdf_pkg::REG_FRAC_DIGITS;
		wr_data  <= sfdf_pkg::CNT_W'(nfrac);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// random item: full patterns, small numbers, decade edges, fraction edges, extremes
	function automatic logic signed [sfdf_pkg::VALUE_W-1:0] pick_value();
		logic [sfdf_pkg::IPART_W-1:0] ip;
		logic [sfdf_pkg::FRAC_W-1:0]  fp;
		logic [sfdf_pkg::VALUE_W-1:0] mag;
		logic                         neg;
		neg = 1'($urandom_range(0, 1));
		fp  = sfdf_pkg::FRAC_W'($urandom);
		ip  = sfdf_pkg::IPART_W'($urandom_range(0, 65535));
		case ($urandom_range(0, 5))
			0, 1: return {1'($urandom_range(0, 1)), 32'($urandom)};
			2: ip = sfdf_pkg::IPART_W'($urandom_range(0, 15));
			3: begin
				case ($urandom_range(0, 4))
					0: ip = 17'd9;
					1: ip = 17'd99;
					2: ip = 17'd999;
					3: ip = 17'd9999;
					default: ip = 17'd65535;
				endcase
				ip = ip + sfdf_pkg::IPART_W'($urandom_range(0, 1));
			end
			4: begin
				case ($urandom_range(0, 3))
					0: fp = 16'h0000;
					1: fp = 16'h0001;
					2: fp = 16'hFFFF;
					default: fp = 16'h8000;
				endcase
			end
			default: begin
				// most negative pattern or largest positive
				ip = neg ? 17'h10000 : 17'h0FFFF;
				fp = neg ? 16'h0000 : 16'hFFFF;
			end
		endcase
		mag = {ip, fp};
		return neg ? -mag : mag;
	endfunction

	initial begin
		int p;
		int n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero, tiny, minus tiny, extremes, a mid value, minus a half
		send_value(33'sd0);
		send_value(33'sd1);
		send_value(-33'sd1);
		send_value(33'sh0_FFFF_FFFF);
		send_value(33'sh1_0000_0000);
		send_value(33'sh1_0000_0001);
		send_value({17'd12345, 16'h8000});
		send_value(-(33'sh0_8000));
		drain_output();

		// no integer and no fraction digits: the point alone, after the sign of a negative value, flagged last
		write_cfg(0, 0);
		send_value(33'sh0_0001_8000);
		send_value(-33'sd1);
		send_value(33'sd0);
		drain_output();

		// both counts above their maxima
		write_cfg(7, 7);
		send_value(33'sh0_FFFF_FFFF);
		send_value(33'sh1_0000_0000);
		send_value({1'b0, 16'd9999, 16'hFFFF});
		drain_output();

		// one integer digit, four fraction digits; a negative that prints only zeros
		write_cfg(1, 4);
		send_value(33'sh0_0009_FFFF);
		send_value(-33'sd6);
		send_value(33'sh0_0000_FFFF);
		drain_output();

		write_cfg(5, 0);
		send_value(33'sh0_0001_0000);
		send_value(-(33'sh0_0002_4000));
		drain_output();

		write_cfg(6, 1);
		send_value(33'sh0_1234_5678);
		send_value(33'sh1_8000_0000);

		// random phases, each with its own settings and a full drain half way
		for (p = 0; p < PHASES; p++) begin
			drain_output();
			case (p)
				0: write_cfg(5, 4);
				1: write_cfg(0, 0);
				2: write_cfg(7, 1);
				3: write_cfg(1, 6);
				default: write_cfg($urandom_range(0, 7), $urandom_range(0, 7));
			endcase
			// one phase runs flat out on both sides
			gaps_on <= (p != 4);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					drain_output();
				send_value(pick_value());
			end
		end
		drain_output();

		if (errors == 0 && chars_due == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
